### src/rsma_pkg.sv
// Package for the running-sum moving average core.
// Holds the sizing constants and the command and status types shared by the
// controller, the datapath and the top level. Depends on nothing else.
package rsma_pkg;

	// Sample width and largest window, with the widths that follow from them.
	localparam int SAMPLE_BITS = 16;
	localparam int MAX_WINDOW  = 64;
	localparam int ADDR_BITS   = $clog2(MAX_WINDOW);
	localparam int LEN_BITS    = $clog2(MAX_WINDOW + 1);
	localparam int SUM_BITS    = SAMPLE_BITS + ADDR_BITS;
	localparam int DIV_STEPS   = SUM_BITS;
	localparam int CNT_BITS    = $clog2(DIV_STEPS + 1);

	// Window length after reset.
	localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(MAX_WINDOW);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;   // take the input item and read its ring slot
		logic update;    // update the sum and ring, load the divider
		logic div_step;  // one restoring division step
		logic load_out;  // move the quotient into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_last;  // the current division step is the final one
	} sts_t;

endpackage

### src/rsma_ifs.sv
// Handshake interfaces for the running-sum moving average core.
// One carries input samples, the other carries averages; both use
// rsma_pkg for their widths.
interface rsma_in_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [rsma_pkg::SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface rsma_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [rsma_pkg::SAMPLE_BITS-1:0] average;
	logic                                   window_full;

	modport source (output valid, output average, output window_full, input ready);
	modport sink   (input valid, input average, input window_full, output ready);
endinterface

### src/rsma_ctrl.sv
// Controller of the running-sum moving average core.
// Sequences capture, update, division and output load for one item at a time
// and owns both handshakes. Uses rsma_pkg for the command and status types.
module rsma_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output rsma_pkg::cmd_t  cmd,
	input  rsma_pkg::sts_t  sts
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_UPD  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	// The output register can take a new result when empty or being emptied.
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands.
	always_comb begin
		state_d      = state_q;
		cmd.capture  = 1'b0;
		cmd.update   = 1'b0;
		cmd.div_step = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d    = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### src/rsma_dp.sv
// Datapath of the running-sum moving average core.
// Holds the sample ring, running sum, position, full flag, window length,
// the restoring divider and the output register. Uses rsma_pkg.
module rsma_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [rsma_pkg::LEN_BITS-1:0]          cfg_wdata,
	input  logic signed [rsma_pkg::SAMPLE_BITS-1:0] sample,
	input  rsma_pkg::cmd_t                         cmd,
	output rsma_pkg::sts_t                         sts,
	output logic signed [rsma_pkg::SAMPLE_BITS-1:0] average,
	output logic                                   window_full
);

	localparam int SB = rsma_pkg::SAMPLE_BITS;
	localparam int AB = rsma_pkg::ADDR_BITS;
	localparam int LB = rsma_pkg::LEN_BITS;
	localparam int WB = rsma_pkg::SUM_BITS;
	localparam int CB = rsma_pkg::CNT_BITS;

	// Sample ring and per-entry valid bits; an entry not valid reads as zero.
	logic [SB-1:0]                   ring_mem [rsma_pkg::MAX_WINDOW];
	logic [rsma_pkg::MAX_WINDOW-1:0] vld_q;

	logic [LB-1:0]          win_len_q;
	logic signed [WB-1:0]   sum_q;
	logic [AB-1:0]          pos_q;
	logic                   full_q;

	logic signed [SB-1:0]   smp_q;
	logic [SB-1:0]          rd_data_q;
	logic                   rd_vld_q;

	logic [LB-1:0]          rem_q;
	logic [WB-1:0]          quo_q;
	logic [LB-1:0]          dvs_q;
	logic                   neg_q;
	logic [CB-1:0]          cnt_q;

	logic signed [SB-1:0]   avg_q;
	logic                   full_out_q;

	logic [LB-1:0]          eff_len;
	logic signed [SB-1:0]   old_val;
	logic signed [WB-1:0]   sum_new;
	logic [WB-1:0]          mag_new;
	logic [LB-1:0]          pos_inc;
	logic                   wrap;
	logic [LB:0]            cand;
	logic                   take;
	logic [WB-1:0]          quo_signed;

	// Clamp the written length into one to the ring depth.
	always_comb begin
		if (win_len_q == '0) begin
			eff_len = LB'(1);
		end else if (win_len_q > rsma_pkg::LEN_RESET) begin
			eff_len = rsma_pkg::LEN_RESET;
		end else begin
			eff_len = win_len_q;
		end
	end

	// New sum, its magnitude, and the advanced position.
	always_comb begin
		old_val = rd_vld_q ? $signed(rd_data_q) : '0;
		sum_new = sum_q - WB'(old_val) + WB'(smp_q);
		mag_new = sum_new[WB-1] ? WB'(-sum_new) : WB'(sum_new);
		pos_inc = LB'(pos_q) + LB'(1);
		wrap    = (pos_inc >= eff_len);
	end

	// One restoring division step: bring down the next dividend bit.
	always_comb begin
		cand = {rem_q, quo_q[WB-1]};
		take = (cand >= {1'b0, dvs_q});
	end

	assign quo_signed = neg_q ? WB'(-quo_q) : quo_q;
	assign sts.div_last = (cnt_q == CB'(1));

	// Ring write and registered read.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rd_data_q <= ring_mem[pos_q];
		end
		if (cmd.update) begin
			ring_mem[pos_q] <= smp_q;
		end
	end

	// Window state: cleared by reset and by a length write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q <= rsma_pkg::LEN_RESET;
			vld_q     <= '0;
			sum_q     <= '0;
			pos_q     <= '0;
			full_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (cfg_we) begin
				win_len_q <= cfg_wdata;
				vld_q     <= '0;
				sum_q     <= '0;
				pos_q     <= '0;
				full_q    <= 1'b0;
			end else if (cmd.update) begin
				vld_q[pos_q] <= 1'b1;
				sum_q        <= sum_new;
				if (wrap) begin
					pos_q  <= '0;
					full_q <= 1'b1;
				end else begin
					pos_q <= pos_inc[AB-1:0];
				end
			end
			if (cmd.update) begin
				cnt_q <= CB'(rsma_pkg::DIV_STEPS);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - CB'(1);
			end
		end
	end

	// Item capture, divider registers and output register.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			smp_q    <= sample;
			rd_vld_q <= vld_q[pos_q];
		end
		if (cmd.update) begin
			rem_q <= '0;
			quo_q <= mag_new;
			neg_q <= sum_new[WB-1];
			dvs_q <= (full_q || wrap) ? eff_len : pos_inc;
		end else if (cmd.div_step) begin
			rem_q <= take ? LB'(cand - {1'b0, dvs_q}) : cand[LB-1:0];
			quo_q <= {quo_q[WB-2:0], take};
		end
		if (cmd.load_out) begin
			avg_q      <= $signed(quo_signed[SB-1:0]);
			full_out_q <= full_q;
		end
	end

	assign average     = avg_q;
	assign window_full = full_out_q;

endmodule

### src/running_sum_moving_average_core.sv
// Running-sum moving average: each sample item yields one average item, the
// sum of the last window_length samples (window_length clamped to 1 to 64; fewer
// until the window first fills) divided by the count held, truncated toward zero.
// The ring slot is read at the edge that accepts the item. The update state then
// updates the sum and ring, the bit-per-cycle restoring divider runs on the
// 22-bit sum, and the final state loads the output register once it is free. A
// new item is not accepted until the last one's result is loaded. The next sample
// is accepted once the result is loaded, even while it still waits to be taken.
// Writing window_length restarts the window at once; write it only while idle.
// Depends on rsma_pkg, rsma_ifs, rsma_ctrl and rsma_dp.
module running_sum_moving_average_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rsma_pkg::LEN_BITS-1:0] cfg_wdata,
	rsma_in_if.sink                       samples,
	rsma_out_if.source                    results
);

	rsma_pkg::cmd_t cmd;
	rsma_pkg::sts_t sts;

	// Sequencing and handshakes.
	rsma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Ring, sum, divider and output register.
	rsma_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.sample      (samples.sample),
		.cmd         (cmd),
		.sts         (sts),
		.average     (results.average),
		.window_full (results.window_full)
	);

endmodule

### tb/tb.sv
// Self-checking bench for running_sum_moving_average_core: sample items go in,
// average items come out and are compared with an in-bench window predictor.
// Depends on rsma_pkg, the rsma_in_if and rsma_out_if interfaces and the core.
module tb;

	localparam int SAMPLE_BITS = rsma_pkg::SAMPLE_BITS;
	localparam int MAX_WINDOW  = rsma_pkg::MAX_WINDOW;
	localparam int ADDR_BITS   = rsma_pkg::ADDR_BITS;
	localparam int LEN_BITS    = rsma_pkg::LEN_BITS;
	localparam int SUM_BITS    = rsma_pkg::SUM_BITS;
	localparam logic [LEN_BITS-1:0] LEN_RESET = rsma_pkg::LEN_RESET;

	localparam int STALL_LIMIT   = 1000;
	localparam int SETTLE_CYCLES = 30;
	localparam int TAIL_CYCLES   = 40;
	localparam int IDLE_PCT      = 15;
	localparam int N_PHASES      = 12;

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] average;
		logic                          window_full;
	} avg_item_t;

	typedef enum int {MIX_FULL, MIX_RAIL_POS, MIX_RAIL_NEG, MIX_SMALL} sample_mix_e;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [LEN_BITS-1:0] cfg_wdata;

	rsma_in_if  in_ch();
	rsma_out_if out_ch();

	running_sum_moving_average_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.samples   (in_ch),
		.results   (out_ch)
	);

	// Window predictor state, mirroring the ring, the sum and the fill tracking.
	logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
	logic signed [SUM_BITS-1:0]    win_sum;
	logic [ADDR_BITS-1:0]          wr_pos;
	logic                          win_filled;
	logic [LEN_BITS-1:0]           win_len;

	logic signed [SAMPLE_BITS-1:0] sample_queue [$];
	avg_item_t                     avg_expect [$];

	logic in_taken;
	logic bench_idle;
	logic steady;
	logic pausing;
	int   fail_count;
	int   stall_cycles;

	// Clock with a period of 8 units.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void clear_window();
		foreach (ring[i])
			ring[i] = '0;
		win_sum    = '0;
		wr_pos     = '0;
		win_filled = 1'b0;
	endfunction

	// Take one sample into the predicted window and return the average it yields.
	function automatic avg_item_t next_average(input logic signed [SAMPLE_BITS-1:0] s);
		int unsigned len;
		int unsigned nxt;
		int unsigned count;
		avg_item_t   res;
		if (win_len == 0)
			len = 1;
		else if (win_len > MAX_WINDOW)
			len = MAX_WINDOW;
		else
			len = win_len;
		if (wr_pos >= len)
			wr_pos = '0;
		win_sum = win_sum - ring[wr_pos] + s;
		ring[wr_pos] = s;
		nxt = int'(wr_pos) + 1;
		if (nxt >= len) begin
			wr_pos     = '0;
			win_filled = 1'b1;
		end else begin
			wr_pos = ADDR_BITS'(nxt);
		end
		count = win_filled ? len : nxt;
		res.average     = SAMPLE_BITS'(int'(win_sum) / int'(count));
		res.window_full = win_filled;
		return res;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] draw_sample(input sample_mix_e mix);
		logic signed [SAMPLE_BITS-1:0] r;
		r = SAMPLE_BITS'($urandom);
		case (mix)
			MIX_RAIL_POS: begin
				if ($urandom_range(9) != 0)
					r = SAMPLE_MAX;
			end
			MIX_RAIL_NEG: begin
				if ($urandom_range(9) != 0)
					r = SAMPLE_MIN;
			end
			MIX_SMALL: begin
				r = r >>> (SAMPLE_BITS - 7);
			end
			default: begin
				if ($urandom_range(7) == 0)
					r = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
			end
		endcase
		return r;
	endfunction

	// Wait until every queued item has gone in and every average has come out.
	task automatic wait_window_idle();
		@(posedge clk);
		do
			@(negedge clk);
		while (!bench_idle);
	endtask

	// Window length is only rewritten once the core has gone quiet.
	task automatic write_window_length(input logic [LEN_BITS-1:0] v);
		wait_window_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Predictor and checker: both channels and the register port are sampled here.
	always @(posedge clk) begin
		avg_item_t want;
		if (!arst_n) begin
			win_len = LEN_RESET;
			clear_window();
			avg_expect.delete();
			in_taken   <= 1'b0;
			bench_idle <= 1'b0;
		end else begin
			if (cfg_we) begin
				win_len = cfg_wdata;
				clear_window();
			end
			if (in_ch.valid && in_ch.ready)
				avg_expect.push_back(next_average(in_ch.sample));
			if (out_ch.valid && out_ch.ready) begin
				if (avg_expect.size() == 0) begin
					$error("average item with none expected: average %0d window_full %0b",
						out_ch.average, out_ch.window_full);
					fail_count++;
				end else begin
					want = avg_expect.pop_front();
					if (out_ch.average !== want.average) begin
						$error("average: expected %0d, got %0d",
							$signed(want.average), $signed(out_ch.average));
						fail_count++;
					end
					if (out_ch.window_full !== want.window_full) begin
						$error("window_full: expected %0b, got %0b",
							want.window_full, out_ch.window_full);
						fail_count++;
					end
				end
			end
			in_taken   <= in_ch.valid && in_ch.ready;
			bench_idle <= (sample_queue.size() == 0) && !in_ch.valid && (avg_expect.size() == 0);
		end
	end

	// Sample driver: presents queued items, idles at random and now and then
	// holds back until the core has returned every outstanding average.
	always @(negedge clk) begin
		if (arst_n && (!in_ch.valid || in_taken)) begin
			if (!pausing && sample_queue.size() != 0 && $urandom_range(299) == 0)
				pausing = 1'b1;
			if (pausing && avg_expect.size() == 0)
				pausing = 1'b0;
			if (sample_queue.size() != 0 && !pausing &&
				(steady || $urandom_range(99) >= IDLE_PCT)) begin
				in_ch.valid  <= 1'b1;
				in_ch.sample <= sample_queue.pop_front();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Average receiver with random back-pressure.
	always @(negedge clk)
		out_ch.ready <= arst_n && (steady || $urandom_range(99) >= IDLE_PCT);

	// Watchdog on cycles in which nothing is accepted.
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Stimulus: directed items first, then random phases over many window lengths.
	initial begin
		logic [LEN_BITS-1:0] phase_len [N_PHASES];
		int unsigned n;
		sample_mix_e mix;

		phase_len    = '{1, 64, 127, 65, 0, 2, 3, 17, 64, 63, 8, 100};
		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		in_ch.valid  = 1'b0;
		in_ch.sample = '0;
		out_ch.ready = 1'b0;
		steady       = 1'b0;
		pausing      = 1'b0;
		fail_count   = 0;
		stall_cycles = 0;
		phase_len[N_PHASES-1] = LEN_BITS'($urandom_range(0, (1 << LEN_BITS) - 1));

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset window of the largest size, with both rails and the values round zero.
		sample_queue = '{SAMPLE_MAX, SAMPLE_MIN, 0, -1, 1, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN};

		// A zero length behaves as a window of one.
		write_window_length('0);
		sample_queue = '{SAMPLE_MIN, SAMPLE_MAX, -1};

		// Window of two, driven to both rails so the sum carries.
		write_window_length(LEN_BITS'(2));
		sample_queue = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, 1};

		for (int i = 0; i < N_PHASES; i++) begin
			write_window_length(phase_len[i]);
			steady = (i == 5);
			mix    = sample_mix_e'(i % 4);
			n      = $urandom_range(85, 115);
			repeat (n)
				sample_queue.push_back(draw_sample(mix));
		end

		wait_window_idle();
		steady = 1'b0;
		repeat (TAIL_CYCLES) @(negedge clk);
		if (avg_expect.size() != 0) begin
			$error("%0d average items never arrived", avg_expect.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
